/* rtl/core/vnh_pkg.sv */
// Shared widths, constants and helpers for the value-noise height sampler.
package vnh_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;

  localparam int SEED_W   = 32;
  localparam int SCALE_W  = 17;
  localparam int HGT_W    = 8;
  localparam int OUT_W    = 24;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam int PX_W    = COORD_BITS + SCALE_W;
  localparam int CELL_W  = 32;
  localparam int WGT_W   = FRAC_BITS + 1;
  localparam int LATENCY = 11;

  localparam logic [CFG_IDX_W-1:0] REG_SEED  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HGT   = CFG_IDX_W'(2);

  localparam logic [SEED_W-1:0]  SEED_RESET  = SEED_W'(42);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(3277);
  localparam logic [HGT_W-1:0]   HGT_RESET   = HGT_W'(35);

  localparam logic [31:0] HASH_C1 = 32'd374761393;
  localparam logic [31:0] HASH_C2 = 32'd668265263;
  localparam logic [31:0] HASH_C3 = 32'd1274126177;

  localparam logic [WGT_W-1:0] ONE_Q = WGT_W'(1) << FRAC_BITS;

  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [WGT_W-1:0]     wgt_t;
  typedef frac_t                corner_vec_t [4];

  function automatic logic [CELL_W-1:0] cell_of(input logic [PX_W-1:0] px);
    logic [63:0] w;
    w = 64'(px);
    return w[FRAC_BITS+CELL_W-1:FRAC_BITS];
  endfunction

  function automatic frac_t frac_of(input logic [PX_W-1:0] px);
    logic [63:0] w;
    w = 64'(px);
    return w[FRAC_BITS-1:0];
  endfunction

endpackage

/* rtl/core/value_noise_height_sample_top.sv */
// Top level of the pipelined 2-D value-noise height sampler.
//
// Usage:
//   Input: drive in_coord_x / in_coord_z and pulse start; a transfer happens
//   at every rising edge with start high and busy low. busy is never raised,
//   so one sample may enter every cycle.
//   Output: out_valid is high for exactly one cycle with out_height_value
//   (unsigned Q8.16). The receiver cannot stall; each result is simply
//   presented once.
//   Throughput is one sample per cycle, set by the fully pipelined scale,
//   hash, ease and blend stages (one multiplier level per stage).
//   Config: cfg_we with cfg_index 0 = seed, 1 = scale, 2 = max height;
//   index 3 is ignored. Write only while no sample is in flight.
//   Reset: synchronous rst_n clears all valid bits and loads the config
//   registers with seed 42, scale 3277, max height 35.
module value_noise_height_sample_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [vnh_pkg::COORD_BITS-1:0]    in_coord_x,
  input  logic [vnh_pkg::COORD_BITS-1:0]    in_coord_z,
  output logic                              out_valid,
  output logic [vnh_pkg::OUT_W-1:0]         out_height_value,
  input  logic                              cfg_we,
  input  logic [vnh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vnh_pkg::CFG_W-1:0]         cfg_wdata
);
  import vnh_pkg::*;

  logic [SEED_W-1:0]  seed_r;
  logic [SCALE_W-1:0] scale_r;
  logic [HGT_W-1:0]   hgt_r;

  logic              v1_r, v2_r;
  logic [PX_W-1:0]   px_r, pz_r;
  logic [CELL_W-1:0] a0_r, a1_r, b0_r, b1_r;
  logic [CELL_W-1:0] a0_nxt, a1_nxt, b0_nxt, b1_nxt;
  frac_t             fx_r, fz_r;

  logic        hash_vld;
  corner_vec_t corner_val;
  wgt_t        sx, omx, sz, omz;
  logic        take;

  assign busy = 1'b0;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= SEED_RESET;
      scale_r <= SCALE_RESET;
      hgt_r   <= HGT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED:  seed_r  <= cfg_wdata[SEED_W-1:0];
        REG_SCALE: scale_r <= cfg_wdata[SCALE_W-1:0];
        REG_HGT:   hgt_r   <= cfg_wdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= take;
      v2_r <= v1_r;
    end
  end

  always_comb begin
    logic [CELL_W-1:0] x0, z0;
    x0 = cell_of(px_r);
    z0 = cell_of(pz_r);
    a0_nxt = x0 + seed_r;
    a1_nxt = x0 + CELL_W'(1) + seed_r;
    b0_nxt = z0 + seed_r;
    b1_nxt = z0 + CELL_W'(1) + seed_r;
  end

  always_ff @(posedge clk) begin
    px_r <= PX_W'(in_coord_x) * PX_W'(scale_r);
    pz_r <= PX_W'(in_coord_z) * PX_W'(scale_r);
    a0_r <= a0_nxt;
    a1_r <= a1_nxt;
    b0_r <= b0_nxt;
    b1_r <= b1_nxt;
    fx_r <= frac_of(px_r);
    fz_r <= frac_of(pz_r);
  end

  vnh_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (v2_r),
    .a0_i  (a0_r),
    .a1_i  (a1_r),
    .b0_i  (b0_r),
    .b1_i  (b1_r),
    .vld_o (hash_vld),
    .val_o (corner_val)
  );

  vnh_ease u_ease (
    .clk   (clk),
    .fx_i  (fx_r),
    .fz_i  (fz_r),
    .sx_o  (sx),
    .omx_o (omx),
    .sz_o  (sz),
    .omz_o (omz)
  );

  vnh_blend u_blend (
    .clk          (clk),
    .rst_n        (rst_n),
    .vld_i        (hash_vld),
    .val_i        (corner_val),
    .sx_i         (sx),
    .omx_i        (omx),
    .sz_i         (sz),
    .omz_i        (omz),
    .max_height_i (hgt_r),
    .vld_o        (out_valid),
    .height_o     (out_height_value)
  );

  // a transfer in always comes out as a result on out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##LATENCY out_valid)
    else $error("result missing after input transfer");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(take, LATENCY))
    else $error("result without matching input transfer");

  // noise is below 1.0, so the height stays below max_height
  a_height_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_height_value) <= (32'(hgt_r) << FRAC_BITS)))
    else $error("height exceeds max_height");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

/* rtl/core/vnh_ease.sv */
// Smoothstep easing of the two cell fractions, aligned to the hash output.
module vnh_ease (
  input  logic           clk,
  input  vnh_pkg::frac_t fx_i,
  input  vnh_pkg::frac_t fz_i,
  output vnh_pkg::wgt_t  sx_o,
  output vnh_pkg::wgt_t  omx_o,
  output vnh_pkg::wgt_t  sz_o,
  output vnh_pkg::wgt_t  omz_o
);
  import vnh_pkg::*;

  localparam int K_W  = FRAC_BITS + 2;
  localparam int SP_W = FRAC_BITS + K_W;

  frac_t fx_r, fz_r, fx2_r, fz2_r;
  frac_t fx2_nxt, fz2_nxt;
  wgt_t  sx_r, sz_r, sx_d_r, sz_d_r, sx_d2_r, sz_d2_r, omx_r, omz_r;
  wgt_t  sx_nxt, sz_nxt;

  function automatic frac_t sq(input frac_t f);
    logic [2*FRAC_BITS-1:0] p;
    p = (2*FRAC_BITS)'(f) * (2*FRAC_BITS)'(f);
    return p[2*FRAC_BITS-1:FRAC_BITS];
  endfunction

  function automatic wgt_t blend(input frac_t f, input frac_t f2);
    logic [K_W-1:0]  k;
    logic [SP_W-1:0] p;
    k = (K_W'(3) << FRAC_BITS) - (K_W'(f) << 1);
    p = SP_W'(f2) * SP_W'(k);
    return WGT_W'(p >> FRAC_BITS);
  endfunction

  always_comb begin
    fx2_nxt = sq(fx_i);
    fz2_nxt = sq(fz_i);
    sx_nxt  = blend(fx_r, fx2_r);
    sz_nxt  = blend(fz_r, fz2_r);
  end

  always_ff @(posedge clk) begin
    fx_r    <= fx_i;
    fz_r    <= fz_i;
    fx2_r   <= fx2_nxt;
    fz2_r   <= fz2_nxt;
    sx_r    <= sx_nxt;
    sz_r    <= sz_nxt;
    sx_d_r  <= sx_r;
    sz_d_r  <= sz_r;
    sx_d2_r <= sx_d_r;
    sz_d2_r <= sz_d_r;
    omx_r   <= ONE_Q - sx_d_r;
    omz_r   <= ONE_Q - sz_d_r;
  end

  assign sx_o  = sx_d2_r;
  assign sz_o  = sz_d2_r;
  assign omx_o = omx_r;
  assign omz_o = omz_r;

endmodule

/* rtl/core/vnh_hash.sv */
// Four-corner multiply/xorshift hash pipeline producing Q0.F corner values.
module vnh_hash (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  input  logic [vnh_pkg::CELL_W-1:0]  a0_i,
  input  logic [vnh_pkg::CELL_W-1:0]  a1_i,
  input  logic [vnh_pkg::CELL_W-1:0]  b0_i,
  input  logic [vnh_pkg::CELL_W-1:0]  b1_i,
  output logic                        vld_o,
  output vnh_pkg::corner_vec_t        val_o
);
  import vnh_pkg::*;

  logic [31:0] pa_r [2];
  logic [31:0] pb_r [2];
  logic [31:0] mx_r [4];
  logic [31:0] mc_r [4];
  frac_t       v_r  [4];
  logic [31:0] mx_nxt [4];
  logic [31:0] mc_nxt [4];
  frac_t       v_nxt  [4];
  logic [3:0]  vld_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [31:0] h;
      logic [63:0] m;
      logic [31:0] g;
      h = pa_r[i % 2] + pb_r[i / 2];
      mx_nxt[i] = h ^ (h >> 13);
      m = 64'(mx_r[i]) * 64'(HASH_C3);
      mc_nxt[i] = m[31:0];
      g = mc_r[i] ^ (mc_r[i] >> 16);
      v_nxt[i] = g[30:31-FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    logic [63:0] t0, t1, t2, t3;
    t0 = 64'(a0_i) * 64'(HASH_C1);
    t1 = 64'(a1_i) * 64'(HASH_C1);
    t2 = 64'(b0_i) * 64'(HASH_C2);
    t3 = 64'(b1_i) * 64'(HASH_C2);
    pa_r[0] <= t0[31:0];
    pa_r[1] <= t1[31:0];
    pb_r[0] <= t2[31:0];
    pb_r[1] <= t3[31:0];
    for (int i = 0; i < 4; i++) begin
      mx_r[i] <= mx_nxt[i];
      mc_r[i] <= mc_nxt[i];
      v_r[i]  <= v_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  assign vld_o = vld_r[3];
  assign val_o = v_r;

endmodule

/* rtl/core/vnh_blend.sv */
// Bilinear blend of corner values and scaling by the height multiplier.
module vnh_blend (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_i,
  input  vnh_pkg::corner_vec_t       val_i,
  input  vnh_pkg::wgt_t              sx_i,
  input  vnh_pkg::wgt_t              omx_i,
  input  vnh_pkg::wgt_t              sz_i,
  input  vnh_pkg::wgt_t              omz_i,
  input  logic [vnh_pkg::HGT_W-1:0]  max_height_i,
  output logic                       vld_o,
  output logic [vnh_pkg::OUT_W-1:0]  height_o
);
  import vnh_pkg::*;

  localparam int P_W  = FRAC_BITS + WGT_W;
  localparam int Q_W  = 2 * WGT_W;
  localparam int HP_W = WGT_W + HGT_W;

  logic [P_W-1:0] p_r [4];
  wgt_t           top_r, bot_r, n_r;
  wgt_t           top_nxt, bot_nxt, n_nxt;
  logic [Q_W-1:0] q0_r, q1_r;
  wgt_t           sz_d_r, omz_d_r, sz_d2_r, omz_d2_r;
  logic [OUT_W-1:0] height_r, height_nxt;
  logic [4:0]     vld_r;

  always_comb begin
    logic [P_W:0]   st, sb;
    logic [Q_W:0]   sn;
    logic [HP_W-1:0] hp;
    st = (P_W+1)'(p_r[0]) + (P_W+1)'(p_r[1]);
    sb = (P_W+1)'(p_r[2]) + (P_W+1)'(p_r[3]);
    top_nxt = WGT_W'(st >> FRAC_BITS);
    bot_nxt = WGT_W'(sb >> FRAC_BITS);
    sn = (Q_W+1)'(q0_r) + (Q_W+1)'(q1_r);
    n_nxt = WGT_W'(sn >> FRAC_BITS);
    hp = HP_W'(n_r) * HP_W'(max_height_i);
    height_nxt = OUT_W'(hp);
  end

  always_ff @(posedge clk) begin
    p_r[0]   <= P_W'(val_i[0]) * P_W'(omx_i);
    p_r[1]   <= P_W'(val_i[1]) * P_W'(sx_i);
    p_r[2]   <= P_W'(val_i[2]) * P_W'(omx_i);
    p_r[3]   <= P_W'(val_i[3]) * P_W'(sx_i);
    sz_d_r   <= sz_i;
    omz_d_r  <= omz_i;
    sz_d2_r  <= sz_d_r;
    omz_d2_r <= omz_d_r;
    top_r    <= top_nxt;
    bot_r    <= bot_nxt;
    q0_r     <= Q_W'(top_r) * Q_W'(omz_d2_r);
    q1_r     <= Q_W'(bot_r) * Q_W'(sz_d2_r);
    n_r      <= n_nxt;
    height_r <= height_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  assign vld_o    = vld_r[4];
  assign height_o = height_r;

endmodule

/* tb/value_noise_height_sample_checker.sv */
// Checker for the value-noise height sampler: predicts each height sample and compares results.
`timescale 1ns / 1ps

module value_noise_height_sample_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [vnh_pkg::COORD_BITS-1:0]    in_coord_x,
  input  logic [vnh_pkg::COORD_BITS-1:0]    in_coord_z,
  input  logic                              out_valid,
  input  logic [vnh_pkg::OUT_W-1:0]         out_height_value,
  input  logic                              cfg_we,
  input  logic [vnh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vnh_pkg::CFG_W-1:0]         cfg_wdata,
  output int                                fail_count,
  output int                                heights_pending,
  output int                                heights_checked
);
  import vnh_pkg::*;

  localparam logic [63:0] UNIT      = 64'd1 << FRAC_BITS;
  localparam logic [63:0] FRAC_MASK = UNIT - 64'd1;
  localparam int          MAX_SHOWN = 10;

  logic [SEED_W-1:0]  seed_q;
  logic [SCALE_W-1:0] scale_q;
  logic [HGT_W-1:0]   hgt_q;
  logic [OUT_W-1:0]   height_q [$];
  int                 errs = 0;
  int                 checked = 0;

  function automatic logic [31:0] lattice_hash(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] acc;
    logic [31:0] h;
    acc = 64'(a) * 64'(HASH_C1) + 64'(b) * 64'(HASH_C2);
    h = acc[31:0];
    acc = 64'(h ^ (h >> 13)) * 64'(HASH_C3);
    h = acc[31:0];
    return h ^ (h >> 16);
  endfunction

  function automatic logic [63:0] corner_height(input logic [31:0] cx, input logic [31:0] cz,
                                                input logic [31:0] seed);
    logic [31:0] h;
    logic [31:0] hx;
    logic [31:0] hz;
    hx = cx + seed;
    hz = cz + seed;
    h = lattice_hash(hx, hz);
    return 64'(h[30:0]) >> (31 - FRAC_BITS);
  endfunction

  function automatic logic [63:0] smooth_weight(input logic [63:0] f);
    logic [63:0] f2;
    f2 = (f * f) >> FRAC_BITS;
    return (f2 * (64'd3 * UNIT - 64'd2 * f)) >> FRAC_BITS;
  endfunction

  function automatic logic [OUT_W-1:0] predict_height(input logic [COORD_BITS-1:0] x,
                                                      input logic [COORD_BITS-1:0] z);
    logic [63:0] px, pz, sx, sz;
    logic [63:0] v00, v10, v01, v11, top_row, bot_row, n, h;
    logic [31:0] x0, z0, x1, z1;
    px = 64'(x) * 64'(scale_q);
    pz = 64'(z) * 64'(scale_q);
    x0 = 32'(px >> FRAC_BITS);
    z0 = 32'(pz >> FRAC_BITS);
    x1 = x0 + 32'd1;
    z1 = z0 + 32'd1;
    sx = smooth_weight(px & FRAC_MASK);
    sz = smooth_weight(pz & FRAC_MASK);
    v00 = corner_height(x0, z0, seed_q);
    v10 = corner_height(x1, z0, seed_q);
    v01 = corner_height(x0, z1, seed_q);
    v11 = corner_height(x1, z1, seed_q);
    top_row = (v00 * (UNIT - sx) + v10 * sx) >> FRAC_BITS;
    bot_row = (v01 * (UNIT - sx) + v11 * sx) >> FRAC_BITS;
    n = (top_row * (UNIT - sz) + bot_row * sz) >> FRAC_BITS;
    h = n * 64'(hgt_q);
    return h[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst_n) begin
      seed_q  <= SEED_RESET;
      scale_q <= SCALE_RESET;
      hgt_q   <= HGT_RESET;
      height_q.delete();
    end else begin
      if (start && !busy) begin
        height_q.push_back(predict_height(in_coord_x, in_coord_z));
      end
      if (out_valid) begin
        if (height_q.size() == 0) begin
          errs++;
          if (errs <= MAX_SHOWN) begin
            $display("%0t: unexpected height sample 0x%06h", $time, out_height_value);
          end
        end else begin
          want = height_q.pop_front();
          checked++;
          if (out_height_value !== want) begin
            errs++;
            if (errs <= MAX_SHOWN) begin
              $display("%0t: height mismatch: expected 0x%06h, got 0x%06h",
                       $time, want, out_height_value);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SEED:  seed_q  <= cfg_wdata[SEED_W-1:0];
          REG_SCALE: scale_q <= cfg_wdata[SCALE_W-1:0];
          REG_HGT:   hgt_q   <= cfg_wdata[HGT_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count      <= errs;
    heights_pending <= height_q.size();
    heights_checked <= checked;
  end

endmodule

/* tb/value_noise_height_sample_top_test.sv */
// Testbench top for the value-noise height sampler: stimulus, register settings and verdict.
`timescale 1ns / 1ps

module value_noise_height_sample_top_test;
  import vnh_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  localparam int LIMIT_CYCLES  = 200000;
  localparam int PHASE_ITEMS   = 50;
  localparam int RANDOM_PHASES = 8;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [COORD_BITS-1:0] in_coord_x = '0;
  logic [COORD_BITS-1:0] in_coord_z = '0;
  logic                  out_valid;
  logic [OUT_W-1:0]      out_height_value;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  int fail_count;
  int heights_pending;
  int heights_checked;
  int coords_sent = 0;
  int settings_used = 1;
  int cycle_count = 0;

  value_noise_height_sample_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_coord_x       (in_coord_x),
    .in_coord_z       (in_coord_z),
    .out_valid        (out_valid),
    .out_height_value (out_height_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  value_noise_height_sample_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_coord_x       (in_coord_x),
    .in_coord_z       (in_coord_z),
    .out_valid        (out_valid),
    .out_height_value (out_height_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .heights_pending  (heights_pending),
    .heights_checked  (heights_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("value_noise_height_sample_top_test failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] seed, input logic [CFG_W-1:0] scale,
                          input logic [CFG_W-1:0] hgt);
    cfg_write(REG_SEED, seed);
    cfg_write(REG_SCALE, scale);
    cfg_write(REG_HGT, hgt);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord();
    logic [COORD_BITS-1:0] top_val;
    top_val = '1;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return top_val;
      2: return COORD_BITS'($urandom_range(0, 3));
      default: return COORD_BITS'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic send_coord(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] z);
    start      <= 1'b1;
    in_coord_x <= x;
    in_coord_z <= z;
    do @(posedge clk); while (busy);
    coords_sent++;
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_gapped(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] z);
    send_coord(x, z);
    idle_gap(pick_gap());
  endtask

  // stop sending and let every outstanding sample come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (heights_pending != 0);
  endtask

  task automatic random_settings();
    logic [CFG_W-1:0] scale_w;
    logic [CFG_W-1:0] hgt_w;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: scale_w = $urandom_range(1, 65536);
      4, 5:       scale_w = $urandom_range(1, 2048);
      6:          scale_w = $urandom;
      default:    scale_w = 65536;
    endcase
    hgt_w = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 255);
    cfg_write(REG_SEED, $urandom);
    cfg_write(REG_SCALE, scale_w);
    cfg_write(REG_HGT, hgt_w);
    if ($urandom_range(0, 3) == 0) cfg_write(REG_SPARE, $urandom);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    bit burst;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, corners of the coordinate range
    send_gapped(10'd0, 10'd0);
    send_gapped(10'd1023, 10'd1023);
    send_gapped(10'd0, 10'd1023);
    send_gapped(10'd1023, 10'd0);
    send_gapped(10'd1, 10'd1);
    drain();

    // unit scale, all-ones seed: corner sums wrap
    set_regs(32'hFFFF_FFFF, 32'd65536, 32'd255);
    send_gapped(10'd1023, 10'd1023);
    send_gapped(10'd0, 10'd0);
    send_gapped(10'd512, 10'd511);
    drain();

    // zero scale: every sample at the origin of cell zero
    set_regs($urandom, 32'd0, 32'd255);
    send_gapped(10'd1023, 10'd1023);
    send_gapped(10'd5, 10'd700);
    drain();

    // largest scale code, zero height
    set_regs($urandom, 32'h0001_FFFF, 32'd0);
    send_gapped(10'd1023, 10'd1023);
    send_gapped(10'd1, 10'd1);
    drain();

    // smallest nonzero scale, unit height, plus a write to the unused index
    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    set_regs(32'd0, 32'd1, 32'd1);
    send_gapped(10'd1023, 10'd1023);
    send_gapped(10'd0, 10'd1);
    drain();

    // half scale: fraction lands on one half for odd coordinates
    set_regs($urandom, 32'd32768, 32'd255);
    send_gapped(10'd1, 10'd3);
    send_gapped(10'd1023, 10'd2);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_settings();
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_coord(pick_coord(), pick_coord());
        if (!burst) idle_gap(pick_gap());
      end
      drain();
    end

    repeat (LATENCY + 5) @(posedge clk);
    $display("Sent %0d coordinate pairs under %0d register settings, %0d heights checked.",
             coords_sent, settings_used, heights_checked);
    if (fail_count == 0) begin
      $display("value_noise_height_sample_top_test passed");
    end else begin
      $display("value_noise_height_sample_top_test failed");
    end
    $finish;
  end

endmodule
